@@ design/kms_pkg.sv @@
`timescale 1ns / 1ps

package kms_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE_MS      = 2'd0;
  localparam logic [1:0] REG_COLUMN_PERIOD_MS = 2'd1;

  // Reset values of the registers and the column timer
  localparam logic [15:0] DEBOUNCE_RESET      = 16'd200;
  localparam logic [9:0]  COLUMN_PERIOD_RESET = 10'd10;

  // Key actions
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_UP     = 3'd1,
    ACT_LEFT   = 3'd2,
    ACT_RIGHT  = 3'd3,
    ACT_DOWN   = 3'd4,
    ACT_BUTTON = 3'd5,
    ACT_EXIT   = 3'd6
  } action_t;

  // One result word
  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_valid;
    logic [3:0] key_code;
    logic [2:0] action;
  } result_t;

  // Action map of the 4x4 pad; anything off the map is no action
  function automatic action_t key_action(input logic [2:0] row, input logic [2:0] col);
    action_t act;
    act = ACT_NONE;
    case ({row, col})
      {3'd0, 3'd0}: act = ACT_BUTTON;  // '1'
      {3'd0, 3'd1}: act = ACT_UP;      // '2'
      {3'd1, 3'd0}: act = ACT_LEFT;    // '4'
      {3'd1, 3'd2}: act = ACT_RIGHT;   // '6'
      {3'd2, 3'd1}: act = ACT_DOWN;    // '8'
      {3'd3, 3'd1}: act = ACT_EXIT;    // '0'
      default:      act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage

@@ design/keypad_matrix_scanner_unit.sv @@
`timescale 1ns / 1ps
// A result word is registered in the output buffer when its input word is taken, or
// parked in its skid entry while the output stalls. Throughput: one word per cycle while
// item_stall is low; the column timer, row lockout counters and key decode are combinational.
// Reset (rst, synchronous): drive on column one, column timer 10, all lockouts
// clear, debounce 200 ms, column period 10 ms, output empty.
module keypad_matrix_scanner_unit
  import kms_pkg::*;
#(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        tick,
  input  logic [3:0]  row_edges,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  column_drive,
  output logic        key_valid,
  output logic [3:0]  key_code,
  output logic [2:0]  action
);

  localparam int CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROWS_USED = (ROWS < 4) ? ROWS : 4;
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  logic [15:0]   debounce_ms;
  logic [9:0]    column_period_ms;
  logic [CW-1:0] driven_column, driven_column_next;
  logic [CW-1:0] next_column, next_column_next;
  logic [15:0]   column_timer, column_timer_next;
  logic [15:0]   row_lockout [ROWS_USED];
  logic [15:0]   row_lockout_next [ROWS_USED];

  logic          accept;
  logic          hit;
  logic [1:0]    win_row;
  logic [7:0]    code_full;
  result_t       res;
  result_t       res_out;
  logic          buf_full;

  assign item_stall = buf_full;
  assign accept     = item_valid & ~buf_full;

  // Config writes; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= DEBOUNCE_RESET;
      column_period_ms <= COLUMN_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_MS:      debounce_ms      <= cfg_data;
        REG_COLUMN_PERIOD_MS: column_period_ms <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Column timer and one-hot column stepping
  always_comb begin
    driven_column_next = driven_column;
    next_column_next   = next_column;
    column_timer_next  = column_timer;
    if (tick) begin
      if (column_timer <= 16'd1) begin
        driven_column_next = next_column;
        next_column_next   = (next_column == COL_LAST) ? '0 : next_column + CW'(1);
        column_timer_next  = (column_period_ms == '0) ? 16'd1 : {6'd0, column_period_ms};
      end else begin
        column_timer_next = column_timer - 16'd1;
      end
    end
  end

  // Row lockouts: count down on tick, then judge edges; highest row wins
  always_comb begin
    logic [15:0] lk;
    hit     = 1'b0;
    win_row = '0;
    for (int r = 0; r < ROWS_USED; r++) begin
      lk = (tick && row_lockout[r] != '0) ? row_lockout[r] - 16'd1 : row_lockout[r];
      if (row_edges[r]) begin
        if (lk == '0) begin
          hit     = 1'b1;
          win_row = 2'(r);
        end
        lk = debounce_ms;
      end
      row_lockout_next[r] = lk;
    end
  end

  // Key decode
  assign code_full = 8'(win_row) * 8'(COLUMNS) + 8'(driven_column_next);

  always_comb begin
    res.column_drive = (8'(driven_column_next) < 8'd4) ?
                       4'(4'b0001 << driven_column_next) : 4'b0000;
    res.key_valid    = hit;
    res.key_code     = hit ? code_full[3:0] : 4'd0;
    res.action       = hit ? key_action(3'(win_row), 3'(driven_column_next)) : ACT_NONE;
  end

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      driven_column <= '0;
      next_column   <= '0;
      column_timer  <= {6'd0, COLUMN_PERIOD_RESET};
      for (int r = 0; r < ROWS_USED; r++) row_lockout[r] <= '0;
    end else if (accept) begin
      driven_column <= driven_column_next;
      next_column   <= next_column_next;
      column_timer  <= column_timer_next;
      for (int r = 0; r < ROWS_USED; r++) row_lockout[r] <= row_lockout_next[r];
    end
  end

  kms_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .load_word    (res),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (res_out)
  );

  assign column_drive = res_out.column_drive;
  assign key_valid    = res_out.key_valid;
  assign key_code     = res_out.key_code;
  assign action       = res_out.action;

endmodule

@@ design/kms_out_buf.sv @@
`timescale 1ns / 1ps

// Output register with one skid entry, so a new word is taken while a
// finished one waits downstream.
module kms_out_buf
  import kms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_word,
  output logic    full,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_word
);

  logic    skid_valid;
  result_t skid_word;
  logic    drain;
  logic    out_free;

  assign drain    = result_valid & ~result_stall;
  assign out_free = ~result_valid | drain;
  assign full     = skid_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        result_valid <= skid_valid | load;
      end
      if (skid_valid) begin
        if (drain) skid_valid <= 1'b0;
      end else if (load && !out_free) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) result_word <= skid_word;
      else if (load) result_word <= load_word;
    end
    if (!skid_valid && load && !out_free) skid_word <= load_word;
  end

endmodule

@@ design/kms_checker.sv @@
`timescale 1ns / 1ps

module kms_checker
  import kms_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [3:0] column_drive,
  input logic       key_valid,
  input logic [3:0] key_code,
  input logic [2:0] action
);

  // A held word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  // Nothing pending right after a reset cycle
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("output not empty after reset");

  // At most one column driven
  a_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(column_drive))
    else $error("column drive not one-hot");

  // No key means zeroed key fields
  a_no_key: assert property (@(posedge clk) disable iff (rst)
    result_valid && !key_valid |-> key_code == 4'd0 && action == ACT_NONE)
    else $error("key fields set without a key");

  // An action only comes with a key
  a_action_key: assert property (@(posedge clk) disable iff (rst)
    result_valid && action != ACT_NONE |-> key_valid)
    else $error("action without accepted key");

endmodule

bind keypad_matrix_scanner_unit kms_checker u_kms_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .column_drive (column_drive),
  .key_valid    (key_valid),
  .key_code     (key_code),
  .action       (action)
);

@@ sim/keypad_matrix_scanner_unit_tb.sv @@
`timescale 1ns / 1ps

module keypad_matrix_scanner_unit_tb;
  import kms_pkg::*;

  // Indexes past the two registers; writes there must be ignored
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  // One word offered to the scanner
  typedef struct packed {
    logic       tick;
    logic [3:0] edges;
  } pad_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        tick = 1'b0;
  logic [3:0]  row_edges = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [3:0]  column_drive;
  logic        key_valid;
  logic [3:0]  key_code;
  logic [2:0]  action;

  keypad_matrix_scanner_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .tick         (tick),
    .row_edges    (row_edges),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .column_drive (column_drive),
    .key_valid    (key_valid),
    .key_code     (key_code),
    .action       (action)
  );

  always #10 clk = ~clk;

  // Words waiting to be sent, and scan results still owed by the block
  pad_word_t pad_words[$];
  result_t   scan_results_due[$];
  int        scan_errors = 0;

  // Scanner shadow: registers, column state and row lockouts
  logic [15:0] sh_debounce = DEBOUNCE_RESET;
  logic [9:0]  sh_period   = COLUMN_PERIOD_RESET;
  logic [1:0]  col_drv     = 2'd0;
  logic [1:0]  col_next    = 2'd0;
  logic [15:0] col_timer   = 16'd10;
  logic [15:0] row_lock [4] = '{16'd0, 16'd0, 16'd0, 16'd0};

  // Keys by row*4 + column
  action_t key_map [16] = '{
    ACT_BUTTON, ACT_UP,   ACT_NONE,  ACT_NONE,
    ACT_LEFT,   ACT_NONE, ACT_RIGHT, ACT_NONE,
    ACT_NONE,   ACT_DOWN, ACT_NONE,  ACT_NONE,
    ACT_NONE,   ACT_EXIT, ACT_NONE,  ACT_NONE
  };

  // Advance the scanner by one word and return the scan result it gives
  function automatic result_t scan_step(input logic tk, input logic [3:0] edges);
    result_t    res;
    logic       hit;
    logic [1:0] win;
    int         r;
    hit = 1'b0;
    win = 2'd0;
    // tick: column timer first, then the lockouts
    if (tk) begin
      if (col_timer <= 16'd1) begin
        col_drv   = col_next;
        col_next  = col_next + 2'd1;
        col_timer = (sh_period == 10'd0) ? 16'd1 : 16'(sh_period);
      end else begin
        col_timer = col_timer - 16'd1;
      end
      for (r = 0; r < 4; r++)
        if (row_lock[r] != 16'd0) row_lock[r] = row_lock[r] - 16'd1;
    end
    // edges against the updated lockouts; highest accepted row wins
    for (r = 0; r < 4; r++) begin
      if (edges[r]) begin
        if (row_lock[r] == 16'd0) begin
          hit = 1'b1;
          win = r[1:0];
        end
        row_lock[r] = sh_debounce;
      end
    end
    res.column_drive = 4'b0001 << col_drv;
    res.key_valid    = hit;
    res.key_code     = hit ? {win, col_drv} : 4'd0;
    res.action       = hit ? key_map[{win, col_drv}] : ACT_NONE;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    scan_errors++;
  endtask

  // Driver: bursts of words with random gaps in between
  pad_word_t nxt_word;
  int        burst_left;
  int        gap_left;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      tick       <= 1'b0;
      row_edges  <= '0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (item_valid && !item_stall) scan_results_due.push_back(scan_step(tick, row_edges));
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pad_words.size() != 0) begin
          nxt_word = pad_words.pop_front();
          tick       <= nxt_word.tick;
          row_edges  <= nxt_word.edges;
          item_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: a random pattern that is redrawn periodically, plus long holds
  int          stall_cyc;
  int          words_taken;
  int          hold_left;
  logic [15:0] stall_pat;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_cyc   = 0;
      words_taken = 0;
      hold_left   = 0;
      stall_pat   = '0;
    end else begin
      if (result_valid && !result_stall) begin
        words_taken++;
        if (words_taken % 350 == 0) hold_left = 64;
      end
      if (stall_cyc % 128 == 0)
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom & $urandom);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= stall_pat[stall_cyc % 16];
      end
      stall_cyc++;
    end
  end

  // Monitor: compare each word taken with the oldest result due
  result_t want_res;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch("word with none due", {column_drive, key_valid, key_code, action}, -1);
      end else begin
        want_res = scan_results_due.pop_front();
        if (column_drive !== want_res.column_drive)
          report_mismatch("column_drive", column_drive, want_res.column_drive);
        if (key_valid !== want_res.key_valid)
          report_mismatch("key_valid", key_valid, want_res.key_valid);
        if (key_code !== want_res.key_code)
          report_mismatch("key_code", key_code, want_res.key_code);
        if (action !== want_res.action)
          report_mismatch("action", action, want_res.action);
      end
    end
  end

  task automatic add_word(input logic tk, input logic [3:0] edges);
    pad_word_t w;
    w.tick  = tk;
    w.edges = edges;
    pad_words.push_back(w);
  endtask

  // Wait until every word is sent and every result has come back
  task automatic wait_idle();
    @(negedge clk);
    while (pad_words.size() != 0 || item_valid || scan_results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write both registers, with ignored writes to the spare indexes in between
  task automatic load_setting(input logic [15:0] deb, input logic [15:0] per);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    int          k;
    idx = '{REG_SPARE_LO, REG_DEBOUNCE_MS, REG_SPARE_HI, REG_COLUMN_PERIOD_MS};
    val = '{16'($urandom), deb, 16'($urandom), per};
    for (k = 0; k < 4; k++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      if (idx[k] == REG_DEBOUNCE_MS) sh_debounce = val[k];
      else if (idx[k] == REG_COLUMN_PERIOD_MS) sh_period = val[k][9:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random words: mostly quiet rows, some single presses, some chatter
  task automatic random_phase(input int tick_pct, input int count);
    int       n;
    int       pick;
    logic [3:0] e;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) e = 4'd0;
      else if (pick < 9) e = 4'b0001 << $urandom_range(0, 3);
      else e = 4'($urandom);
      add_word($urandom_range(0, 99) < tick_pct, e);
    end
    wait_idle();
  endtask

  int j;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: no lockout, one ms per column, every key of the pad
    load_setting(16'd0, 16'd1);
    @(negedge clk);
    add_word(1'b0, 4'h0);
    add_word(1'b0, 4'hF);
    // ten ticks drain the reset timer while column one stays driven
    add_word(1'b1, 4'h0);
    add_word(1'b1, 4'hF);
    add_word(1'b1, 4'h1);
    add_word(1'b1, 4'h2);
    add_word(1'b1, 4'h4);
    add_word(1'b1, 4'h8);
    add_word(1'b1, 4'h3);
    add_word(1'b1, 4'h5);
    add_word(1'b1, 4'hA);
    add_word(1'b1, 4'h0);
    // each further tick steps one column; the other rows held on it
    for (j = 0; j < 3; j++) begin
      add_word(1'b1, 4'h1);
      add_word(1'b0, 4'h2);
      add_word(1'b0, 4'h4);
      add_word(1'b0, 4'h8);
    end
    wait_idle();

    // Settings from the extremes inward; period upper bits are masked off
    load_setting(16'd200, 16'd10);
    random_phase(90, 125);
    load_setting(16'd1, 16'hFC01);
    random_phase(50, 125);
    load_setting(16'd65535, 16'd1000);
    random_phase(80, 100);
    load_setting(16'd7, 16'd0);
    random_phase(50, 125);
    load_setting(16'd3, 16'd2);
    random_phase(60, 125);
    load_setting(16'd12, 16'd5);
    random_phase(70, 125);
    load_setting(16'd0, 16'd3);
    random_phase(40, 125);
    load_setting(16'($urandom_range(0, 40)), 16'($urandom_range(0, 12)));
    random_phase($urandom_range(20, 90), 125);

    // Let any stray word show up before judging
    repeat (10) @(negedge clk);
    if (scan_results_due.size() != 0)
      report_mismatch("results left at end", scan_results_due.size(), 0);
    if (scan_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
